>>> design/caps_pkg.sv
package caps_pkg;

   // Field and arithmetic widths
   localparam int PRESSURE_BITS = 24;
   localparam int OPENING_BITS  = 10;
   localparam int OPEN_FIELD_BITS = 11;
   localparam int TIME_BITS     = 20;
   localparam int VOL_BITS      = 16;
   localparam int MASK_BITS     = 5;
   localparam int CS_BITS       = 25;
   localparam int CST_BITS      = CS_BITS + TIME_BITS;
   localparam int NUM_BITS      = CST_BITS + 8;
   localparam int DEN_BITS      = 51;
   localparam int DVD_BITS      = PRESSURE_BITS + NUM_BITS;
   localparam int QUO_BITS      = 43;
   localparam int REM_INIT_BITS = DVD_BITS - QUO_BITS;
   localparam int SW            = 48;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 24;

   // Physical constants in fixed point
   localparam logic [PRESSURE_BITS-1:0] PMAX = '1;
   localparam logic [OPEN_FIELD_BITS-1:0] FULL_OPEN = OPEN_FIELD_BITS'(1 << OPENING_BITS);
   localparam logic [24:0] FLOW_DEN      = 25'd20000000;
   localparam logic [PRESSURE_BITS-1:0] SUPPLY_SOURCE = 24'd6400000;
   localparam logic [CS_BITS-1:0] VALVE_CS  = CS_BITS'(4 << OPENING_BITS);
   localparam logic [CS_BITS-1:0] SUPPLY_CS = CS_BITS'(1 << OPENING_BITS);
   localparam logic [CS_BITS-1:0] HATCH_CS_PER = CS_BITS'(2000);
   localparam logic [CS_BITS-1:0] LOCK_CS_PER  = CS_BITS'(20000);

   // Valve mask bit positions
   localparam int VALVE_CABIN_SUPPLY   = 0;
   localparam int VALVE_HATCH          = 1;
   localparam int VALVE_INNER          = 2;
   localparam int VALVE_OUTER          = 3;
   localparam int VALVE_AIRLOCK_SUPPLY = 4;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CABIN_VOLUME    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AIRLOCK_VOLUME  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DOCK_VOLUME     = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_PRESSURE = 2'd3;

   // Register reset values
   localparam logic [VOL_BITS-1:0] CABIN_VOLUME_RESET   = 16'd6144;
   localparam logic [VOL_BITS-1:0] AIRLOCK_VOLUME_RESET = 16'd1024;
   localparam logic [VOL_BITS-1:0] DOCK_VOLUME_RESET    = 16'd512;
   localparam logic [PRESSURE_BITS-1:0] TARGET_RESET    = 24'd1600000;
   localparam logic [PRESSURE_BITS-1:0] PRESSURE_RESET  = 24'd1600000;

   typedef struct packed {
      logic [TIME_BITS-1:0]       time_step;
      logic [PRESSURE_BITS-1:0]   ambient_pressure;
      logic [PRESSURE_BITS-1:0]   dynamic_pressure;
      logic                       is_docked;
      logic [OPEN_FIELD_BITS-1:0] nose_cone_open;
      logic [OPEN_FIELD_BITS-1:0] hatch_open;
      logic [OPEN_FIELD_BITS-1:0] outer_lock_open;
      logic [OPEN_FIELD_BITS-1:0] inner_lock_open;
      logic [MASK_BITS-1:0]       valve_open_mask;
   } req_type;

   typedef struct packed {
      logic [PRESSURE_BITS-1:0] cabin_pressure_out;
      logic [PRESSURE_BITS-1:0] airlock_pressure_out;
      logic [PRESSURE_BITS-1:0] hatch_outside_pressure;
      logic [PRESSURE_BITS-1:0] lock_outside_pressure;
   } rsp_type;

   typedef enum logic [2:0] {
      EX_HATCH,
      EX_OUTER,
      EX_INNER,
      EX_SUP_CAB,
      EX_SUP_AIR
   } exchange_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RAM_MUL,
      ST_RAM_ADD,
      ST_SELECT,
      ST_MUL_CT,
      ST_MUL_DEN,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_ACC_HI,
      ST_DIVIDE,
      ST_APPLY,
      ST_EQ_MUL1,
      ST_EQ_MUL2,
      ST_EQ_ADD,
      ST_EQ_APPLY,
      ST_DONE
   } state_type;

endpackage

>>> design/cabin_airlock_pressure_step_core.sv
// Cabin and airlock pressure stepper.
// The req_ channel carries one simulation tick per transaction (time step,
// outside pressures, docking flag, openings and valve mask). For each tick the
// block updates its cabin, airlock and outer-lock pressures through five gas
// exchanges and returns one transaction on the rsp_ channel with all four
// pressures. A transaction is taken when valid is high and stall is low.
// Volumes and the supply ceiling are to be written on the csr_ port only while idle; the block does not enforce it.
// One 32x32 multiplier and a one-bit-per-cycle restoring divider are
// shared by every exchange. Each flow term costs 4 multiply steps, one add
// and one divide step per bit of the 43-bit quotient; an equilibrium costs
// 3 more steps and another division. A tick is shortest with all paths
// closed and longest with every exchange open and both pairs mixing.
// req_stall is high for the whole of a tick; one tick is in work at a time.
// The result sits in an output register, so a new tick is taken while the
// previous result still waits; if the receiver stalls longer than a whole
// tick, the finished tick holds until the output register is free.
// Reset (synchronous, active high) sets cabin and airlock to 100 kPa, the
// outer lock to zero and the registers to their defaults.
module cabin_airlock_pressure_step_core
   import caps_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   state_type state_ff, state_in;
   exchange_type ex_ff;

   // Configuration
   logic [VOL_BITS-1:0]      cabin_vol_ff, airlock_vol_ff, dock_vol_ff;
   logic [PRESSURE_BITS-1:0] target_ff;

   // Kept pressures
   logic [PRESSURE_BITS-1:0] cabin_ff, air_ff, outer_ff;

   // Captured tick
   logic [TIME_BITS-1:0]       t_ff;
   logic [PRESSURE_BITS-1:0]   amb_ff, dyn_ff;
   logic                       docked_ff;
   logic [OPEN_FIELD_BITS-1:0] nose_ff;
   logic [MASK_BITS-1:0]       mask_ff;
   logic [CS_BITS-1:0]         cs_hatch_ff, cs_outer_ff, cs_inner_ff;

   // Shared arithmetic
   logic                     side_ff, eq_ff;
   logic [CST_BITS-1:0]      cst_ff;
   logic [DEN_BITS-1:0]      den_ff;
   logic [DVD_BITS-1:0]      acc_ff;
   logic [CST_BITS-1:0]      hi_ff;
   logic [DEN_BITS-1:0]      rem_ff, dvs_ff;
   logic [QUO_BITS-1:0]      dvd_ff, quo_ff;
   logic [5:0]               cnt_ff;
   logic signed [SW-1:0]     n1_ff;

   logic                     rsp_valid_ff;
   rsp_type                  rsp_data_ff;

   logic [31:0]              mul_a, mul_b;
   logic [63:0]              mul_p;

   function automatic logic [VOL_BITS-1:0] vol_of(input logic [VOL_BITS-1:0] v);
      return (v == '0) ? VOL_BITS'(1) : v;
   endfunction

   function automatic logic [OPEN_FIELD_BITS-1:0] open_of(
      input logic [OPEN_FIELD_BITS-1:0] o);
      return (o > FULL_OPEN) ? FULL_OPEN : o;
   endfunction

   function automatic logic [PRESSURE_BITS-1:0] sat(input logic signed [SW-1:0] n);
      logic [PRESSURE_BITS-1:0] r;
      if (n < 0) begin
         r = '0;
      end else if (n > $signed(SW'(PMAX))) begin
         r = PMAX;
      end else begin
         r = n[PRESSURE_BITS-1:0];
      end
      return r;
   endfunction

   function automatic exchange_type next_ex(input exchange_type e);
      exchange_type r;
      case (e)
         EX_HATCH:   r = EX_OUTER;
         EX_OUTER:   r = EX_INNER;
         EX_INNER:   r = EX_SUP_CAB;
         default:    r = EX_SUP_AIR;
      endcase
      return r;
   endfunction

   // Signed views of the kept pressures
   logic signed [SW-1:0] cabin_s, air_s, outer_s, amb_s, src_s, target_s;
   assign cabin_s  = SW'(cabin_ff);
   assign air_s    = SW'(air_ff);
   assign outer_s  = SW'(outer_ff);
   assign amb_s    = SW'(amb_ff);
   assign src_s    = SW'(SUPPLY_SOURCE);
   assign target_s = SW'(target_ff);

   logic [VOL_BITS-1:0] vc, va, vd;
   assign vc = vol_of(cabin_vol_ff);
   assign va = vol_of(airlock_vol_ff);
   assign vd = vol_of(dock_vol_ff);

   // Operands of the exchange in work
   logic signed [SW-1:0]     pdiff, base_p, fixed_q, pair_p2, sdelta, n_new, n2;
   logic [VOL_BITS-1:0]      job_vol, pair_v2;
   logic [CS_BITS-1:0]       job_cs;
   logic [PRESSURE_BITS-1:0] mag;
   logic                     neg, is_pair, active, is_last, overshoot;
   logic [NUM_BITS-1:0]      num;
   logic [DVD_BITS-1:0]      dividend;
   logic [DEN_BITS:0]        trial;
   logic                     fits;

   always_comb begin
      pdiff   = '0;
      base_p  = cabin_s;
      fixed_q = amb_s;
      job_vol = vc;
      job_cs  = cs_hatch_ff;
      active  = 1'b0;
      case (ex_ff)
         EX_HATCH: begin
            pdiff   = amb_s - cabin_s;
            base_p  = cabin_s;
            fixed_q = amb_s;
            job_vol = vc;
            job_cs  = cs_hatch_ff;
            active  = (cs_hatch_ff != '0);
         end
         EX_OUTER: begin
            pdiff   = outer_s - air_s;
            base_p  = air_s;
            fixed_q = outer_s;
            job_vol = (docked_ff && side_ff) ? vd : va;
            job_cs  = cs_outer_ff;
            active  = (cs_outer_ff != '0);
         end
         EX_INNER: begin
            pdiff   = cabin_s - air_s;
            base_p  = air_s;
            job_vol = side_ff ? vc : va;
            job_cs  = cs_inner_ff;
            active  = (cs_inner_ff != '0);
         end
         EX_SUP_CAB: begin
            pdiff   = src_s - cabin_s;
            base_p  = cabin_s;
            job_vol = vc;
            job_cs  = SUPPLY_CS;
            active  = mask_ff[VALVE_CABIN_SUPPLY];
         end
         default: begin
            pdiff   = src_s - air_s;
            base_p  = air_s;
            job_vol = va;
            job_cs  = SUPPLY_CS;
            active  = mask_ff[VALVE_AIRLOCK_SUPPLY];
         end
      endcase
   end

   assign neg     = pdiff < 0;
   assign mag     = neg ? PRESSURE_BITS'(-pdiff) : PRESSURE_BITS'(pdiff);
   assign is_pair = (ex_ff == EX_INNER) || ((ex_ff == EX_OUTER) && docked_ff);
   assign is_last = (ex_ff == EX_SUP_AIR);
   assign pair_p2 = (ex_ff == EX_OUTER) ? outer_s : cabin_s;
   assign pair_v2 = (ex_ff == EX_OUTER) ? vd : vc;
   assign num     = {cst_ff, 8'b0};
   assign sdelta  = neg ? -SW'(quo_ff) : SW'(quo_ff);

   // Single-volume result: clamp against overshoot or cap at the ceiling
   always_comb begin
      n_new = base_p + sdelta;
      if ((ex_ff == EX_SUP_CAB) || (ex_ff == EX_SUP_AIR)) begin
         if (n_new > target_s) begin
            n_new = target_s;
         end
      end else if (base_p > fixed_q) begin
         if (n_new < fixed_q) begin
            n_new = fixed_q;
         end
      end else if (n_new > fixed_q) begin
         n_new = fixed_q;
      end
   end

   // Pair result: the step overshoots when the difference changes sign
   assign n2 = pair_p2 - sdelta;
   assign overshoot = (air_s != pair_p2) && (n1_ff != n2) &&
                      ((air_s > pair_p2) != (n1_ff > n2));

   // Shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_RAM_MUL: begin
            mul_a = 32'(dyn_ff);
            mul_b = 32'(nose_ff);
         end
         ST_MUL_CT: begin
            mul_a = 32'(job_cs);
            mul_b = 32'(t_ff);
         end
         ST_MUL_DEN: begin
            mul_a = 32'(FLOW_DEN);
            mul_b = 32'(job_vol);
         end
         ST_MUL_LO: begin
            mul_a = 32'(mag);
            mul_b = num[31:0];
         end
         ST_MUL_HI: begin
            mul_a = 32'(mag);
            mul_b = 32'(num[NUM_BITS-1:32]);
         end
         ST_EQ_MUL1: begin
            mul_a = 32'(air_ff);
            mul_b = 32'(va);
         end
         ST_EQ_MUL2: begin
            mul_a = 32'(pair_p2[PRESSURE_BITS-1:0]);
            mul_b = 32'(pair_v2);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_p = 64'(mul_a) * 64'(mul_b);

   // Dividend for the divider load and one restoring step
   assign dividend = acc_ff + (eq_ff ? DVD_BITS'(hi_ff) : (DVD_BITS'(hi_ff) << 32));
   assign trial    = {rem_ff, dvd_ff[QUO_BITS-1]};
   assign fits     = trial >= {1'b0, dvs_ff};

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_RAM_MUL;
         ST_RAM_MUL: state_in = ST_RAM_ADD;
         ST_RAM_ADD: state_in = ST_SELECT;
         ST_SELECT: begin
            if (active) begin
               state_in = ST_MUL_CT;
            end else if (is_last) begin
               state_in = ST_DONE;
            end
         end
         ST_MUL_CT:  state_in = ST_MUL_DEN;
         ST_MUL_DEN: state_in = ST_MUL_LO;
         ST_MUL_LO:  state_in = ST_MUL_HI;
         ST_MUL_HI:  state_in = ST_ACC_HI;
         ST_ACC_HI:  state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (cnt_ff == 6'(QUO_BITS - 1)) begin
               state_in = eq_ff ? ST_EQ_APPLY : ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (is_pair && !side_ff) begin
               state_in = ST_MUL_CT;
            end else if (is_pair && overshoot) begin
               state_in = ST_EQ_MUL1;
            end else begin
               state_in = is_last ? ST_DONE : ST_SELECT;
            end
         end
         ST_EQ_MUL1:  state_in = ST_EQ_MUL2;
         ST_EQ_MUL2:  state_in = ST_EQ_ADD;
         ST_EQ_ADD:   state_in = ST_DIVIDE;
         ST_EQ_APPLY: state_in = is_last ? ST_DONE : ST_SELECT;
         ST_DONE:     if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cabin_vol_ff   <= CABIN_VOLUME_RESET;
         airlock_vol_ff <= AIRLOCK_VOLUME_RESET;
         dock_vol_ff    <= DOCK_VOLUME_RESET;
         target_ff      <= TARGET_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CABIN_VOLUME:    cabin_vol_ff   <= csr_data[VOL_BITS-1:0];
            CSR_AIRLOCK_VOLUME:  airlock_vol_ff <= csr_data[VOL_BITS-1:0];
            CSR_DOCK_VOLUME:     dock_vol_ff    <= csr_data[VOL_BITS-1:0];
            CSR_TARGET_PRESSURE: target_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   // Kept pressures and exchange control
   always_ff @(posedge clock) begin
      if (reset) begin
         cabin_ff <= PRESSURE_RESET;
         air_ff   <= PRESSURE_RESET;
         outer_ff <= '0;
         ex_ff    <= EX_HATCH;
         side_ff  <= 1'b0;
         eq_ff    <= 1'b0;
      end else begin
         case (state_ff)
            ST_RAM_ADD: begin
               if (!docked_ff) begin
                  outer_ff <= sat(amb_s + SW'(hi_ff[CST_BITS-1:OPENING_BITS]));
               end
               ex_ff <= EX_HATCH;
            end
            ST_SELECT: begin
               side_ff <= 1'b0;
               eq_ff   <= 1'b0;
               if (!active) begin
                  ex_ff <= next_ex(ex_ff);
               end
            end
            ST_APPLY: begin
               if (is_pair && !side_ff) begin
                  side_ff <= 1'b1;
               end else if (is_pair && overshoot) begin
                  eq_ff <= 1'b1;
               end else begin
                  if (is_pair) begin
                     air_ff <= sat(n1_ff);
                     if (ex_ff == EX_OUTER) begin
                        outer_ff <= sat(n2);
                     end else begin
                        cabin_ff <= sat(n2);
                     end
                  end else if ((ex_ff == EX_HATCH) || (ex_ff == EX_SUP_CAB)) begin
                     cabin_ff <= sat(n_new);
                  end else begin
                     air_ff <= sat(n_new);
                  end
                  ex_ff <= next_ex(ex_ff);
               end
            end
            ST_EQ_APPLY: begin
               air_ff <= sat(SW'(quo_ff));
               if (ex_ff == EX_OUTER) begin
                  outer_ff <= sat(SW'(quo_ff));
               end else begin
                  cabin_ff <= sat(SW'(quo_ff));
               end
               ex_ff <= next_ex(ex_ff);
            end
            default: ;
         endcase
      end
   end

   // Capture the tick and run the arithmetic datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            t_ff        <= req_data.time_step;
            amb_ff      <= req_data.ambient_pressure;
            dyn_ff      <= req_data.dynamic_pressure;
            docked_ff   <= req_data.is_docked;
            nose_ff     <= open_of(req_data.nose_cone_open);
            mask_ff     <= req_data.valve_open_mask;
            cs_hatch_ff <= (req_data.valve_open_mask[VALVE_HATCH] ? VALVE_CS : '0) +
                           CS_BITS'(HATCH_CS_PER * CS_BITS'(open_of(req_data.hatch_open)));
            cs_outer_ff <= (req_data.valve_open_mask[VALVE_OUTER] ? VALVE_CS : '0) +
                           CS_BITS'(LOCK_CS_PER * CS_BITS'(open_of(req_data.outer_lock_open)));
            cs_inner_ff <= (req_data.valve_open_mask[VALVE_INNER] ? VALVE_CS : '0) +
                           CS_BITS'(LOCK_CS_PER * CS_BITS'(open_of(req_data.inner_lock_open)));
         end
         ST_RAM_MUL: hi_ff  <= CST_BITS'(mul_p);
         ST_MUL_CT:  cst_ff <= CST_BITS'(mul_p);
         ST_MUL_DEN: den_ff <= {mul_p[DEN_BITS-OPENING_BITS-1:0], {OPENING_BITS{1'b0}}};
         ST_MUL_LO:  acc_ff <= DVD_BITS'(mul_p);
         ST_MUL_HI:  hi_ff  <= CST_BITS'(mul_p);
         ST_EQ_MUL1: acc_ff <= DVD_BITS'(mul_p);
         ST_EQ_MUL2: hi_ff  <= CST_BITS'(mul_p);
         ST_ACC_HI, ST_EQ_ADD: begin
            rem_ff <= DEN_BITS'(dividend[DVD_BITS-1:QUO_BITS]);
            dvd_ff <= dividend[QUO_BITS-1:0];
            dvs_ff <= eq_ff ? DEN_BITS'(32'(va) + 32'(pair_v2)) : den_ff;
            cnt_ff <= '0;
         end
         ST_DIVIDE: begin
            rem_ff <= fits ? DEN_BITS'(trial - {1'b0, dvs_ff}) : DEN_BITS'(trial);
            dvd_ff <= {dvd_ff[QUO_BITS-2:0], 1'b0};
            quo_ff <= {quo_ff[QUO_BITS-2:0], fits};
            cnt_ff <= cnt_ff + 6'd1;
         end
         ST_APPLY: begin
            if (!side_ff) begin
               n1_ff <= air_s + sdelta;
            end
         end
         default: ;
      endcase
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_data_ff.cabin_pressure_out     <= cabin_ff;
         rsp_data_ff.airlock_pressure_out   <= air_ff;
         rsp_data_ff.hatch_outside_pressure <= amb_ff;
         rsp_data_ff.lock_outside_pressure  <= outer_ff;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> design/caps_checker.sv
module caps_checker
   import caps_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // No result survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A held result keeps its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // An accepted tick keeps the block busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block took a second tick at once");

   // A result appears only at the end of a tick in work
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a tick in work");

endmodule

bind cabin_airlock_pressure_step_core caps_checker u_caps_checker (.*);

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import caps_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   localparam int CYCLE_LIMIT  = 4000000;
   localparam int HOLD_AFTER   = 150;
   localparam int HOLD_CYCLES  = 3000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_CABIN_VOLUME;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   // Pending ticks and predicted pressure transactions
   req_type tick_queue[$];
   rsp_type pressure_queue[$];
   int      error_count = 0;
   int      ticks_taken = 0;
   int      cycle_count = 0;

   // Predictor copy of registers and pressures
   longint unsigned vol_cabin, vol_airlock, vol_dock, supply_ceiling;
   longint          cab_p, air_p, lock_p;

   cabin_airlock_pressure_step_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic longint clamp_pressure(input longint p);
      if (p < 0) return 0;
      if (p > longint'(PMAX)) return longint'(PMAX);
      return p;
   endfunction

   function automatic longint unsigned clamp_open(input logic [OPEN_FIELD_BITS-1:0] o);
      return (o > FULL_OPEN) ? longint'(FULL_OPEN) : longint'(o);
   endfunction

   function automatic longint unsigned eff_volume(input longint unsigned v);
      return (v == 0) ? 1 : v;
   endfunction

   // Signed pressure change for a difference flowing into one volume
   function automatic longint flow_step(input longint pdiff, input longint unsigned cs,
                                        input longint unsigned t, input longint unsigned vol);
      logic [127:0] prod;
      logic [127:0] den;
      logic [63:0]  mag;
      logic [127:0] q;
      mag  = (pdiff < 0) ? -pdiff : pdiff;
      prod = 128'(mag) * 128'((cs * t) << 8);
      den  = 128'(20000000) * 128'(1 << OPENING_BITS) * 128'(vol);
      q    = prod / den;
      return (pdiff < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
   endfunction

   // Exchange with a fixed outside pressure, never passing it
   function automatic longint vent_to(input longint p, input longint q,
                                      input longint unsigned cs, input longint unsigned t,
                                      input longint unsigned vol);
      longint n;
      n = p + flow_step(q - p, cs, t, vol);
      if (p > q) begin
         if (n < q) n = q;
      end else begin
         if (n > q) n = q;
      end
      return clamp_pressure(n);
   endfunction

   // Two closed volumes; mix to equilibrium on overshoot
   function automatic void mix_volumes(inout longint p1, input longint unsigned v1,
                                       inout longint p2, input longint unsigned v2,
                                       input longint unsigned cs, input longint unsigned t);
      longint d, n1, n2, s1, s2;
      d  = p2 - p1;
      n1 = p1 + flow_step(d, cs, t, v1);
      n2 = p2 - flow_step(d, cs, t, v2);
      s1 = (p1 > p2) ? 1 : ((p1 < p2) ? -1 : 0);
      s2 = (n1 > n2) ? 1 : ((n1 < n2) ? -1 : 0);
      if (s1 * s2 < 0) begin
         n1 = (p1 * longint'(v1) + p2 * longint'(v2)) / longint'(v1 + v2);
         n2 = n1;
      end
      p1 = clamp_pressure(n1);
      p2 = clamp_pressure(n2);
   endfunction

   function automatic longint oxygen_feed(input longint p, input longint unsigned t,
                                          input longint unsigned vol);
      longint n;
      n = p + flow_step(longint'(SUPPLY_SOURCE) - p, longint'(SUPPLY_CS), t, vol);
      if (n > longint'(supply_ceiling)) n = longint'(supply_ceiling);
      return clamp_pressure(n);
   endfunction

   // Advance the pressure state by one tick and return the expected transaction
   function automatic rsp_type advance_pressures(input req_type r);
      longint unsigned t, nose, hatch, olock, ilock, vc, va, vd, cs;
      longint          amb;
      rsp_type         o;
      t     = r.time_step;
      amb   = longint'(r.ambient_pressure);
      nose  = clamp_open(r.nose_cone_open);
      hatch = clamp_open(r.hatch_open);
      olock = clamp_open(r.outer_lock_open);
      ilock = clamp_open(r.inner_lock_open);
      vc    = eff_volume(vol_cabin);
      va    = eff_volume(vol_airlock);
      vd    = eff_volume(vol_dock);
      if (!r.is_docked)
         lock_p = clamp_pressure(amb + longint'((longint'(r.dynamic_pressure) * nose)
                                                >> OPENING_BITS));
      cs = (r.valve_open_mask[VALVE_HATCH] ? longint'(VALVE_CS) : 0) + 2000 * hatch;
      if (cs != 0) cab_p = vent_to(cab_p, amb, cs, t, vc);
      cs = (r.valve_open_mask[VALVE_OUTER] ? longint'(VALVE_CS) : 0) + 20000 * olock;
      if (cs != 0) begin
         if (r.is_docked) mix_volumes(air_p, va, lock_p, vd, cs, t);
         else air_p = vent_to(air_p, lock_p, cs, t, va);
      end
      cs = (r.valve_open_mask[VALVE_INNER] ? longint'(VALVE_CS) : 0) + 20000 * ilock;
      if (cs != 0) mix_volumes(air_p, va, cab_p, vc, cs, t);
      if (r.valve_open_mask[VALVE_CABIN_SUPPLY]) cab_p = oxygen_feed(cab_p, t, vc);
      if (r.valve_open_mask[VALVE_AIRLOCK_SUPPLY]) air_p = oxygen_feed(air_p, t, va);
      o.cabin_pressure_out     = cab_p[PRESSURE_BITS-1:0];
      o.airlock_pressure_out   = air_p[PRESSURE_BITS-1:0];
      o.hatch_outside_pressure = amb[PRESSURE_BITS-1:0];
      o.lock_outside_pressure  = lock_p[PRESSURE_BITS-1:0];
      return o;
   endfunction

   task automatic report_mismatch(input string field, input logic [PRESSURE_BITS-1:0] got,
                                  input logic [PRESSURE_BITS-1:0] want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, field, got, want);
      error_count++;
   endtask

   // Driver: bursts of ticks with random gaps, payload held while stalled
   int burst_left = 1;
   int gap_left = 0;
   always @(posedge clock) begin
      logic    next_valid;
      req_type next_data;
      next_valid = req_valid;
      next_data  = req_data;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            pressure_queue.push_back(advance_pressures(req_data));
            ticks_taken++;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (tick_queue.size() > 0) begin
               next_data  = tick_queue.pop_front();
               next_valid = 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 25);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
               end
            end
         end
      end
      req_valid <= next_valid;
      req_data  <= next_data;
   end

   // Receiver: stall in random modes, with one long hold-off
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   int  stall_mode = 0;
   int  mode_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && ticks_taken >= HOLD_AFTER) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(20, 300);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // Monitor: compare each transaction with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pressure_queue.size() == 0) begin
            $display("unexpected transaction at cycle %0d", cycle_count);
            error_count++;
         end else begin
            want = pressure_queue.pop_front();
            if (rsp_data.cabin_pressure_out !== want.cabin_pressure_out)
               report_mismatch("cabin", rsp_data.cabin_pressure_out, want.cabin_pressure_out);
            if (rsp_data.airlock_pressure_out !== want.airlock_pressure_out)
               report_mismatch("airlock", rsp_data.airlock_pressure_out,
                               want.airlock_pressure_out);
            if (rsp_data.hatch_outside_pressure !== want.hatch_outside_pressure)
               report_mismatch("hatch outside", rsp_data.hatch_outside_pressure,
                               want.hatch_outside_pressure);
            if (rsp_data.lock_outside_pressure !== want.lock_outside_pressure)
               report_mismatch("lock outside", rsp_data.lock_outside_pressure,
                               want.lock_outside_pressure);
         end
      end
   end

   // Timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** cabin_airlock_pressure_step_core: FAILED **");
         $finish;
      end
   end

   function automatic logic [PRESSURE_BITS-1:0] pick_pressure();
      case ($urandom_range(0, 4))
         0: return PRESSURE_BITS'($urandom);
         1: return PRESSURE_BITS'($urandom_range(0, 2000000));
         2: return ($urandom_range(0, 1) == 0) ? '0 : PMAX;
         default: return PRESSURE_BITS'($urandom_range(1400000, 1700000));
      endcase
   endfunction

   function automatic logic [OPEN_FIELD_BITS-1:0] pick_opening();
      case ($urandom_range(0, 5))
         0, 1: return '0;
         2: return FULL_OPEN;
         3: return OPEN_FIELD_BITS'($urandom_range(0, 2047));
         default: return OPEN_FIELD_BITS'($urandom_range(0, 64));
      endcase
   endfunction

   function automatic req_type random_tick();
      req_type r;
      r.time_step        = ($urandom_range(0, 3) == 0) ? TIME_BITS'($urandom) :
                                                         TIME_BITS'($urandom_range(0, 40000));
      r.ambient_pressure = pick_pressure();
      r.dynamic_pressure = ($urandom_range(0, 2) == 0) ? PRESSURE_BITS'($urandom) :
                                                         PRESSURE_BITS'($urandom_range(0, 50000));
      r.is_docked        = 1'($urandom_range(0, 1));
      r.nose_cone_open   = pick_opening();
      r.hatch_open       = pick_opening();
      r.outer_lock_open  = pick_opening();
      r.inner_lock_open  = pick_opening();
      r.valve_open_mask  = MASK_BITS'($urandom);
      return r;
   endfunction

   function automatic req_type make_tick(input logic [TIME_BITS-1:0] t,
                                         input logic [PRESSURE_BITS-1:0] amb, dyn,
                                         input logic dock,
                                         input logic [OPEN_FIELD_BITS-1:0] nose, hatch,
                                         input logic [OPEN_FIELD_BITS-1:0] olock, ilock,
                                         input logic [MASK_BITS-1:0] mask);
      req_type r;
      r = '{t, amb, dyn, dock, nose, hatch, olock, ilock, mask};
      return r;
   endfunction

   // Write all four registers back to back, then drop the enable
   task automatic write_registers(input logic [VOL_BITS-1:0] cab, air, dock,
                                  input logic [PRESSURE_BITS-1:0] target);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_CABIN_VOLUME;
      csr_data  <= CSR_DATA_BITS'(cab);
      @(posedge clock);
      csr_index <= CSR_AIRLOCK_VOLUME;
      csr_data  <= CSR_DATA_BITS'(air);
      @(posedge clock);
      csr_index <= CSR_DOCK_VOLUME;
      csr_data  <= CSR_DATA_BITS'(dock);
      @(posedge clock);
      csr_index <= CSR_TARGET_PRESSURE;
      csr_data  <= target;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      vol_cabin      = cab;
      vol_airlock    = air;
      vol_dock       = dock;
      supply_ceiling = target;
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (tick_queue.size() != 0 || req_valid || pressure_queue.size() != 0);
   endtask

   task automatic queue_random(input int count);
      repeat (count) tick_queue.push_back(random_tick());
   endtask

   initial begin
      vol_cabin      = CABIN_VOLUME_RESET;
      vol_airlock    = AIRLOCK_VOLUME_RESET;
      vol_dock       = DOCK_VOLUME_RESET;
      supply_ceiling = TARGET_RESET;
      cab_p  = PRESSURE_RESET;
      air_p  = PRESSURE_RESET;
      lock_p = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed ticks: closed, extremes, docking, over-full openings, supplies
      tick_queue.push_back(make_tick(0, 0, 0, 0, 0, 0, 0, 0, 0));
      tick_queue.push_back(make_tick(1000, 1600000, 0, 1, 0, 0, 0, 0, 0));
      tick_queue.push_back(make_tick('1, PMAX, PMAX, 0, FULL_OPEN, FULL_OPEN, FULL_OPEN,
                                     FULL_OPEN, '1));
      tick_queue.push_back(make_tick('1, 0, 0, 0, '1, '1, '1, '1, '1));
      tick_queue.push_back(make_tick(20000, PMAX, PMAX, 0, '1, 0, 0, 0, 0));
      tick_queue.push_back(make_tick(20000, 1600000, 0, 0, 0, 0, 0, 0, 5'b00010));
      tick_queue.push_back(make_tick(20000, 0, 0, 0, 0, 0, 0, 0, 5'b01000));
      tick_queue.push_back(make_tick(20000, 0, 0, 0, 0, 0, 0, 0, 5'b00100));
      tick_queue.push_back(make_tick(500000, 0, 0, 0, 0, 0, 0, 0, 5'b10001));
      tick_queue.push_back(make_tick(16000, 1000000, 0, 1, 0, 0, 20, 0, 5'b01000));
      tick_queue.push_back(make_tick('1, 1000000, 0, 1, 0, 0, FULL_OPEN, 0, 0));
      tick_queue.push_back(make_tick(3000, 1600000, 1234, 0, 512, 300, 1, 1, 0));
      tick_queue.push_back(make_tick('1, 1600000, 0, 1, 0, 0, 0, FULL_OPEN, 5'b00100));
      tick_queue.push_back(make_tick(10, 1200000, 7777, 1, 1500, 1025, 1100, 1024, '1));
      tick_queue.push_back(make_tick(0, 1600000, 0, 0, FULL_OPEN, FULL_OPEN, FULL_OPEN,
                                     FULL_OPEN, '1));
      queue_random(300);
      wait_idle();

      // Zero volumes behave as one, supply ceiling at zero
      write_registers(0, 0, 0, 0);
      queue_random(100);
      wait_idle();

      // Largest volumes and ceiling, supplies above the source pressure
      write_registers('1, '1, '1, PMAX);
      tick_queue.push_back(make_tick('1, 0, 0, 0, 0, 0, 0, 0, 5'b10001));
      queue_random(200);
      wait_idle();

      // Random settings
      repeat (3) begin
         write_registers(VOL_BITS'($urandom_range(1, 65535)),
                         VOL_BITS'($urandom_range(1, 65535)),
                         VOL_BITS'($urandom_range(1, 65535)),
                         PRESSURE_BITS'($urandom_range(0, 16777215)));
         queue_random(100);
         wait_idle();
      end

      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("** cabin_airlock_pressure_step_core: PASSED **");
      end else begin
         $display("** cabin_airlock_pressure_step_core: FAILED **");
      end
      $finish;
   end

endmodule
